// File: sv/rcsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rcsp_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam logic [23:0] MAX_CHUNK_RST = 24'd128;
  localparam logic [23:0] MASK24        = 24'hFFFFFF;
  localparam logic [16:0] CHAN_EXT_BASE = 17'd64;
  localparam logic [5:0]  ID_TWO_BYTE   = 6'd0;
  localparam logic [5:0]  ID_THREE_BYTE = 6'd1;

  localparam logic [1:0] FMT_FULL  = 2'd0;
  localparam logic [1:0] FMT_NOSID = 2'd1;
  localparam logic [1:0] FMT_TS    = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [2:0] {
    PH_BASIC     = 3'd0,
    PH_BASIC_EXT = 3'd1,
    PH_MSG       = 3'd2,
    PH_EXT_TS    = 3'd3,
    PH_PAYLOAD   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [23:0] len;
    logic [23:0] left;
    logic [7:0]  kind;
    logic [31:0] stream;
  } hist_ent_t;

  typedef struct packed {
    logic              en;
    logic [16:0]       chan;
    hist_ent_t         ent;
  } hist_wr_t;

  function automatic logic [3:0] hdr_size(input logic [1:0] fmt);
    logic [3:0] r;
    case (fmt)
      FMT_FULL:  r = 4'd11;
      FMT_NOSID: r = 4'd7;
      FMT_TS:    r = 4'd3;
      default:   r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic chan_tracked(input logic [16:0] chan);
    return {15'd0, chan} < 32'(TABLE_DEPTH);
  endfunction

endpackage
`default_nettype wire

// File: sv/rcsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: sv/rcsp_hist.sv
`timescale 1ns / 1ps
`default_nettype none
module rcsp_hist (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [16:0]         rd_chan_i,
  input  wire rcsp_pkg::hist_wr_t  wr_i,
  output rcsp_pkg::hist_ent_t      rd_ent_o,
  output logic                     busy_o
);
  import rcsp_pkg::*;

  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_q, clr_d;
  logic             rd_trk_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             fwd_vld_q;
  logic [IDX_W-1:0] fwd_idx_q;
  hist_ent_t        fwd_ent_q;
  logic             we;
  logic [IDX_W-1:0] waddr;
  hist_ent_t        wdata, rdata;
  logic             wr_ok;

  assign wr_ok = wr_i.en && chan_tracked(wr_i.chan);

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == IDX_W'(TABLE_DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else begin
      we    = wr_ok;
      waddr = wr_i.chan[IDX_W-1:0];
      wdata = wr_i.ent;
    end
  end

  rcsp_ram #(
    .WIDTH($bits(hist_ent_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_chan_i[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      fwd_vld_q <= 1'b0;
      rd_trk_q  <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      rd_trk_q  <= chan_tracked(rd_chan_i);
      if (wr_ok && !clr_q) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_chan_i[IDX_W-1:0];
    if (wr_ok && !clr_q) begin
      fwd_idx_q <= wr_i.chan[IDX_W-1:0];
      fwd_ent_q <= wr_i.ent;
    end
  end

  // the last write covers a read issued in the same cycle
  always_comb begin
    if (!rd_trk_q) begin
      rd_ent_o = '0;
    end else if (fwd_vld_q && fwd_idx_q == rd_idx_q) begin
      rd_ent_o = fwd_ent_q;
    end else begin
      rd_ent_o = rdata;
    end
  end

  assign busy_o = clr_q;
endmodule
`default_nettype wire

// File: sv/rtmp_chunk_stream_parser.sv
// a payload byte is registered and appears on the output in the cycle after its input beat
// a chunk header waits in the finish state for its history read, then is registered out
// throughput: one byte per cycle while the output is not stalled; input pauses per chunk header
// reset: clears control state, then sweeps the 512-entry history ram to zero
// with in_ready_o low; configuration writes are taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
module rtmp_chunk_stream_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic      [16:0] stream_chan_o,
  output logic      [31:0] time_ms_o,
  output logic      [23:0] msg_len_o,
  output logic      [7:0]  msg_kind_o,
  output logic      [31:0] msg_stream_o,
  output logic      [23:0] chunk_len_o,
  output logic      [23:0] bytes_left_o,
  output logic      [1:0]  hdr_fmt_o,
  output logic      [7:0]  data_byte_o,
  output logic             last_o,
  output logic             chan_untracked_o
);
  import rcsp_pkg::*;

  logic [23:0] cfg_q;
  phase_e      phase_q, phase_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [1:0]  fmt_q, fmt_d;
  logic [16:0] chan_q, chan_d;
  logic [31:0] time_q, time_d;
  logic [23:0] len_q, len_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] stream_q, stream_d;
  logic [23:0] clen_q, clen_d;
  logic [23:0] left_q, left_d;
  logic [23:0] pcnt_q, pcnt_d;
  logic        fin_q, fin_d;
  logic        out_vld_q, out_vld_d;
  logic        busy, slot_free, acc, fin_go, emit_data, data_last;
  logic [3:0]  fcnt_n;
  logic [23:0] pcnt_n, src, src_left, cap;
  hist_ent_t   hist;
  hist_wr_t    hwr;

  // config port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {8'd0, cfg_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= MAX_CHUNK_RST;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      cfg_q <= pwdata[23:0];
    end
  end

  rcsp_hist u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_chan_i(chan_d),
    .wr_i     (hwr),
    .rd_ent_o (hist),
    .busy_o   (busy)
  );

  assign slot_free  = !out_vld_q || out_ready_i;
  assign in_ready_o = !busy && !fin_q && slot_free;
  assign acc        = in_valid_i && in_ready_o;
  assign fin_go     = fin_q && slot_free;
  assign fcnt_n     = fcnt_q + 4'd1;
  assign pcnt_n     = pcnt_q + 24'd1;
  assign cap        = (cfg_q == 24'd0) ? 24'd1 : cfg_q;

  always_comb begin
    phase_d   = phase_q;
    fcnt_d    = fcnt_q;
    fmt_d     = fmt_q;
    chan_d    = chan_q;
    time_d    = time_q;
    len_d     = len_q;
    kind_d    = kind_q;
    stream_d  = stream_q;
    clen_d    = clen_q;
    left_d    = left_q;
    pcnt_d    = pcnt_q;
    fin_d     = fin_q;
    emit_data = 1'b0;
    data_last = 1'b0;
    src_left  = 24'd0;
    src       = 24'd0;
    hwr       = '0;
    if (acc) begin
      unique case (phase_q)
        PH_BASIC_EXT: begin
          if (fcnt_q == 4'd1) begin
            chan_d = chan_q + {9'd0, in_byte_i};
            fcnt_d = 4'd2;
          end else begin
            if (fcnt_q == 4'd2) chan_d = chan_q + {1'b0, in_byte_i, 8'd0};
            else chan_d = chan_q + {9'd0, in_byte_i};
            time_d = '0; len_d = '0; kind_d = '0; stream_d = '0; fcnt_d = '0;
            if (fmt_q == FMT_NONE) fin_d = 1'b1;
            else phase_d = PH_MSG;
          end
        end
        PH_MSG: begin
          if (fcnt_q < 4'd3) time_d = {8'd0, time_q[15:0], in_byte_i};
          else if (fcnt_q < 4'd6) len_d = {len_q[15:0], in_byte_i};
          else if (fcnt_q == 4'd6) kind_d = in_byte_i;
          else begin
            case (fcnt_q)
              4'd7:    stream_d[7:0]   = stream_q[7:0] | in_byte_i;
              4'd8:    stream_d[15:8]  = stream_q[15:8] | in_byte_i;
              4'd9:    stream_d[23:16] = stream_q[23:16] | in_byte_i;
              4'd10:   stream_d[31:24] = stream_q[31:24] | in_byte_i;
              default: stream_d = stream_q;
            endcase
          end
          fcnt_d = fcnt_n;
          if (fcnt_n >= hdr_size(fmt_q)) begin
            if (time_d == {8'd0, MASK24}) begin
              time_d  = '0;
              fcnt_d  = '0;
              phase_d = PH_EXT_TS;
            end else begin
              fin_d = 1'b1;
            end
          end
        end
        PH_EXT_TS: begin
          time_d = {time_q[23:0], in_byte_i};
          fcnt_d = fcnt_n;
          if (fcnt_n >= 4'd4) fin_d = 1'b1;
        end
        PH_PAYLOAD: begin
          pcnt_d    = pcnt_n;
          emit_data = 1'b1;
          data_last = pcnt_n >= clen_q;
          if (data_last) begin
            phase_d = PH_BASIC;
            fcnt_d  = '0;
          end
        end
        default: begin
          fmt_d = in_byte_i[7:6];
          if (in_byte_i[5:0] == ID_TWO_BYTE || in_byte_i[5:0] == ID_THREE_BYTE) begin
            chan_d  = CHAN_EXT_BASE;
            fcnt_d  = (in_byte_i[5:0] == ID_THREE_BYTE) ? 4'd1 : 4'd0;
            phase_d = PH_BASIC_EXT;
          end else begin
            chan_d = {11'd0, in_byte_i[5:0]};
            time_d = '0; len_d = '0; kind_d = '0; stream_d = '0; fcnt_d = '0;
            if (in_byte_i[7:6] == FMT_NONE) fin_d = 1'b1;
            else phase_d = PH_MSG;
          end
        end
      endcase
    end
    if (fin_go) begin
      case (fmt_q)
        FMT_FULL: begin
        end
        FMT_NOSID: begin
          time_d   = hist.time_ms + time_q;
          stream_d = hist.stream;
        end
        FMT_TS: begin
          time_d   = hist.time_ms + time_q;
          len_d    = hist.len;
          kind_d   = hist.kind;
          stream_d = hist.stream;
          src_left = hist.left;
        end
        default: begin
          time_d   = hist.time_ms;
          len_d    = hist.len;
          kind_d   = hist.kind;
          stream_d = hist.stream;
          src_left = hist.left;
        end
      endcase
      src      = (src_left != 24'd0) ? src_left : len_d;
      clen_d   = (src > cap) ? cap : src;
      left_d   = src - clen_d;
      pcnt_d   = '0;
      fcnt_d   = '0;
      phase_d  = (clen_d == 24'd0) ? PH_BASIC : PH_PAYLOAD;
      fin_d    = 1'b0;
      hwr.en   = 1'b1;
      hwr.chan = chan_q;
      hwr.ent  = '{time_ms: time_d, len: len_d, left: left_d, kind: kind_d,
                   stream: stream_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BASIC;
      fcnt_q   <= '0;
      fmt_q    <= '0;
      chan_q   <= '0;
      time_q   <= '0;
      len_q    <= '0;
      kind_q   <= '0;
      stream_q <= '0;
      clen_q   <= '0;
      left_q   <= '0;
      pcnt_q   <= '0;
      fin_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fcnt_q   <= fcnt_d;
      fmt_q    <= fmt_d;
      chan_q   <= chan_d;
      time_q   <= time_d;
      len_q    <= len_d;
      kind_q   <= kind_d;
      stream_q <= stream_d;
      clen_q   <= clen_d;
      left_q   <= left_d;
      pcnt_q   <= pcnt_d;
      fin_q    <= fin_d;
    end
  end

  // output beat register
  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    if (fin_go || emit_data) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go || emit_data) begin
      kind_o           <= emit_data ? KIND_DATA : KIND_HDR;
      stream_chan_o    <= chan_q;
      time_ms_o        <= emit_data ? time_q : time_d;
      msg_len_o        <= emit_data ? len_q : len_d;
      msg_kind_o       <= emit_data ? kind_q : kind_d;
      msg_stream_o     <= emit_data ? stream_q : stream_d;
      chunk_len_o      <= emit_data ? clen_q : clen_d;
      bytes_left_o     <= emit_data ? left_q : left_d;
      hdr_fmt_o        <= fmt_q;
      data_byte_o      <= emit_data ? in_byte_i : 8'd0;
      last_o           <= emit_data ? data_last : (clen_d == 24'd0);
      chan_untracked_o <= !chan_tracked(chan_q);
    end
  end

  assign out_valid_o = out_vld_q;
endmodule
`default_nettype wire

// File: sv/rcsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rcsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        kind_o,
  input wire logic [16:0] stream_chan_o,
  input wire logic [23:0] msg_len_o,
  input wire logic [23:0] chunk_len_o,
  input wire logic [23:0] bytes_left_o,
  input wire logic        chan_untracked_o
);
  import rcsp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chunk_len_o))
    else $error("output beat dropped or changed while stalled");

  a_data_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DATA |-> chunk_len_o != 24'd0)
    else $error("payload beat in an empty chunk");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chunk_len_o <= msg_len_o && bytes_left_o <= msg_len_o)
    else $error("chunk or remaining length exceeds message length");

  a_untracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chan_untracked_o == !chan_tracked(stream_chan_o))
    else $error("untracked flag does not match stream id");
endmodule

bind rtmp_chunk_stream_parser rcsp_checker u_rcsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .kind_o          (kind_o),
  .stream_chan_o   (stream_chan_o),
  .msg_len_o       (msg_len_o),
  .chunk_len_o     (chunk_len_o),
  .bytes_left_o    (bytes_left_o),
  .chan_untracked_o(chan_untracked_o)
);
`default_nettype wire

// File: bench/rtmp_chunk_checker.sv
`timescale 1ns / 1ps
module rtmp_chunk_checker #(
  parameter logic [2:0] CAP_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [16:0] stream_chan_i,
  input  logic [31:0] time_ms_i,
  input  logic [23:0] msg_len_i,
  input  logic [7:0]  msg_kind_i,
  input  logic [31:0] msg_stream_i,
  input  logic [23:0] chunk_len_i,
  input  logic [23:0] bytes_left_i,
  input  logic [1:0]  hdr_fmt_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        chan_untracked_i,
  output int          fail_count_o,
  output int          pending_o
);
  import rcsp_pkg::*;

  typedef struct {
    logic        kind;
    logic [16:0] chan;
    logic [31:0] stamp;
    logic [23:0] mlen;
    logic [7:0]  mkind;
    logic [31:0] msid;
    logic [23:0] clen;
    logic [23:0] left;
    logic [1:0]  fmt;
    logic [7:0]  data;
    logic        last;
    logic        untracked;
  } beat_t;

  beat_t       expected_beats[$];

  // parser mirror
  phase_e      phase;
  logic [3:0]  fcnt;
  logic [1:0]  fmt;
  logic [16:0] chan;
  logic [31:0] stamp;
  logic [23:0] mlen;
  logic [7:0]  mkind;
  logic [31:0] msid;
  logic [23:0] clen;
  logic [23:0] left;
  logic [23:0] pcnt;
  logic [23:0] cap;
  logic [31:0] hist_time[TABLE_DEPTH];
  logic [23:0] hist_len[TABLE_DEPTH];
  logic [23:0] hist_left[TABLE_DEPTH];
  logic [7:0]  hist_kind[TABLE_DEPTH];
  logic [31:0] hist_sid[TABLE_DEPTH];

  function automatic logic [3:0] header_bytes(input logic [1:0] f);
    case (f)
      FMT_FULL:  return 4'd11;
      FMT_NOSID: return 4'd7;
      FMT_TS:    return 4'd3;
      default:   return 4'd0;
    endcase
  endfunction

  task push_beat(input logic k, input logic [7:0] d, input logic l);
    beat_t e;
    e.kind = k; e.chan = chan; e.stamp = stamp; e.mlen = mlen; e.mkind = mkind;
    e.msid = msid; e.clen = clen; e.left = left; e.fmt = fmt; e.data = d;
    e.last = l; e.untracked = ({15'd0, chan} >= 32'(TABLE_DEPTH));
    expected_beats.push_back(e);
  endtask

  task close_header();
    bit          tracked;
    int          idx;
    logic [31:0] pt, ps;
    logic [23:0] pl, pr, src_left, src, lim;
    logic [7:0]  pk;
    tracked = {15'd0, chan} < 32'(TABLE_DEPTH);
    idx = tracked ? int'(chan) : 0;
    pt = tracked ? hist_time[idx] : '0;
    pl = tracked ? hist_len[idx] : '0;
    pr = tracked ? hist_left[idx] : '0;
    pk = tracked ? hist_kind[idx] : '0;
    ps = tracked ? hist_sid[idx] : '0;
    case (fmt)
      FMT_FULL: begin
        src_left = '0;
      end
      FMT_NOSID: begin
        stamp = pt + stamp; msid = ps; src_left = '0;
      end
      FMT_TS: begin
        stamp = pt + stamp; mlen = pl; mkind = pk; msid = ps; src_left = pr;
      end
      default: begin
        stamp = pt; mlen = pl; mkind = pk; msid = ps; src_left = pr;
      end
    endcase
    src = (src_left != 0) ? src_left : mlen;
    lim = (cap == 0) ? 24'd1 : cap;
    clen = (src > lim) ? lim : src;
    left = src - clen;
    if (tracked) begin
      hist_time[idx] = stamp; hist_len[idx] = mlen; hist_left[idx] = left;
      hist_kind[idx] = mkind; hist_sid[idx] = msid;
    end
    pcnt = '0;
    fcnt = '0;
    phase = (clen == 0) ? PH_BASIC : PH_PAYLOAD;
    push_beat(KIND_HDR, 8'd0, clen == 0);
  endtask

  task open_msg_header();
    stamp = '0; mlen = '0; mkind = '0; msid = '0; fcnt = '0;
    if (header_bytes(fmt) == 0) close_header();
    else phase = PH_MSG;
  endtask

  task parse_byte(input logic [7:0] b);
    int i;
    case (phase)
      PH_BASIC_EXT: begin
        if (fcnt == 4'd1) begin
          chan = chan + {9'd0, b};
          fcnt = 4'd2;
        end else begin
          if (fcnt == 4'd2) chan = chan + {1'b0, b, 8'd0};
          else chan = chan + {9'd0, b};
          open_msg_header();
        end
      end
      PH_MSG: begin
        i = fcnt;
        if (i < 3) stamp = {8'd0, stamp[15:0], b};
        else if (i < 6) mlen = {mlen[15:0], b};
        else if (i == 6) mkind = b;
        else if (i < 11) msid = msid | ({24'd0, b} << (8 * (i - 7)));
        fcnt = fcnt + 4'd1;
        if (fcnt >= header_bytes(fmt)) begin
          // raw 24-bit field of all ones announces the extended timestamp
          if (stamp == 32'h00FF_FFFF) begin
            stamp = '0;
            fcnt = '0;
            phase = PH_EXT_TS;
          end else begin
            close_header();
          end
        end
      end
      PH_EXT_TS: begin
        stamp = {stamp[23:0], b};
        fcnt = fcnt + 4'd1;
        if (fcnt >= 4'd4) close_header();
      end
      PH_PAYLOAD: begin
        pcnt = pcnt + 24'd1;
        push_beat(KIND_DATA, b, pcnt >= clen);
        if (pcnt >= clen) begin
          phase = PH_BASIC;
          fcnt = '0;
        end
      end
      default: begin
        fmt = b[7:6];
        if (b[5:0] == ID_TWO_BYTE) begin
          chan = CHAN_EXT_BASE; fcnt = 4'd0; phase = PH_BASIC_EXT;
        end else if (b[5:0] == ID_THREE_BYTE) begin
          chan = CHAN_EXT_BASE; fcnt = 4'd1; phase = PH_BASIC_EXT;
        end else begin
          chan = {11'd0, b[5:0]};
          open_msg_header();
        end
      end
    endcase
  endtask

  task check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t e;
    if (!rst_ni) begin
      phase = PH_BASIC; fcnt = '0; fmt = '0; chan = '0; stamp = '0; mlen = '0;
      mkind = '0; msid = '0; clen = '0; left = '0; pcnt = '0;
      cap = MAX_CHUNK_RST;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        hist_time[k] = '0; hist_len[k] = '0; hist_left[k] = '0;
        hist_kind[k] = '0; hist_sid[k] = '0;
      end
      expected_beats.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        cap = pwdata[23:0];
      if (in_valid_i && in_ready_i)
        parse_byte(in_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat kind=%0d chan=%0d", kind_i, stream_chan_i);
          fail_count_o++;
        end else begin
          e = expected_beats.pop_front();
          check_field("kind", 32'(e.kind), 32'(kind_i));
          check_field("stream_chan", 32'(e.chan), 32'(stream_chan_i));
          check_field("time_ms", e.stamp, time_ms_i);
          check_field("msg_len", 32'(e.mlen), 32'(msg_len_i));
          check_field("msg_kind", 32'(e.mkind), 32'(msg_kind_i));
          check_field("msg_stream", e.msid, msg_stream_i);
          check_field("chunk_len", 32'(e.clen), 32'(chunk_len_i));
          check_field("bytes_left", 32'(e.left), 32'(bytes_left_i));
          check_field("hdr_fmt", 32'(e.fmt), 32'(hdr_fmt_i));
          check_field("data_byte", 32'(e.data), 32'(data_byte_i));
          check_field("last", 32'(e.last), 32'(last_i));
          check_field("chan_untracked", 32'(e.untracked), 32'(chan_untracked_i));
        end
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

// File: bench/rtmp_chunk_stream_parser_tb.sv
`timescale 1ns / 1ps
module rtmp_chunk_stream_parser_tb;
  import rcsp_pkg::*;

  localparam logic [2:0] REG_MAX_CHUNK = 3'd0;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         PHASE_BYTES   = 70;
  localparam int         MAX_CHAN      = 65599;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o, out_ready_i;
  logic        kind_o, last_o, chan_untracked_o;
  logic [16:0] stream_chan_o;
  logic [31:0] time_ms_o, msg_stream_o;
  logic [23:0] msg_len_o, chunk_len_o, bytes_left_o;
  logic [7:0]  msg_kind_o, data_byte_o;
  logic [1:0]  hdr_fmt_o;
  int          fail_count, pending;

  // what the sender must know to frame well-formed payloads
  logic [23:0] chan_len[MAX_CHAN + 1];
  logic [23:0] chan_left[MAX_CHAN + 1];
  logic [23:0] cap_now;
  int          cycles, sent_bytes, sent_chunks, cap_settings;
  bit          quiet, hold_req;

  rtmp_chunk_stream_parser uut (.*);

  rtmp_chunk_checker #(.CAP_ADDR(REG_MAX_CHUNK)) chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .in_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .kind_i(kind_o), .stream_chan_i(stream_chan_o), .time_ms_i(time_ms_o),
    .msg_len_i(msg_len_o), .msg_kind_i(msg_kind_o), .msg_stream_i(msg_stream_o),
    .chunk_len_i(chunk_len_o), .bytes_left_i(bytes_left_o), .hdr_fmt_i(hdr_fmt_o),
    .data_byte_i(data_byte_o), .last_i(last_o), .chan_untracked_i(chan_untracked_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[rtmp_chunk_stream_parser] ERROR");
    $finish;
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  function automatic logic [23:0] payload_bytes(input int ch, input logic [1:0] f,
                                                input logic [23:0] len);
    logic [23:0] l, r, src;
    bit          tracked;
    tracked = ch < TABLE_DEPTH;
    l = (f == FMT_FULL || f == FMT_NOSID) ? len : (tracked ? chan_len[ch] : 24'd0);
    r = (f == FMT_FULL || f == FMT_NOSID) ? 24'd0 : (tracked ? chan_left[ch] : 24'd0);
    src = (r != 0) ? r : l;
    return (src > cap_now) ? cap_now : src;
  endfunction

  // three_byte forces the 3-byte basic header where the id would fit the 2-byte form
  task send_chunk(input int ch, input logic [1:0] f, input bit three_byte,
                  input logic [23:0] raw_ts, input logic [31:0] ext_ts,
                  input logic [23:0] len, input logic [7:0] mk, input logic [31:0] sid);
    logic [23:0] n, l, src;
    int          c;
    n = payload_bytes(ch, f, len);
    c = ch - 64;
    if (ch < 64) begin
      send_byte({f, 6'(ch)});
    end else if (c < 256 && !three_byte) begin
      send_byte({f, ID_TWO_BYTE});
      send_byte(8'(c));
    end else begin
      send_byte({f, ID_THREE_BYTE});
      send_byte(c[7:0]);
      send_byte(c[15:8]);
    end
    if (f != FMT_NONE) begin
      send_byte(raw_ts[23:16]); send_byte(raw_ts[15:8]); send_byte(raw_ts[7:0]);
    end
    if (f == FMT_FULL || f == FMT_NOSID) begin
      send_byte(len[23:16]); send_byte(len[15:8]); send_byte(len[7:0]);
      send_byte(mk);
    end
    if (f == FMT_FULL) begin
      send_byte(sid[7:0]); send_byte(sid[15:8]);
      send_byte(sid[23:16]); send_byte(sid[31:24]);
    end
    if (f != FMT_NONE && raw_ts == MASK24) begin
      send_byte(ext_ts[31:24]); send_byte(ext_ts[23:16]);
      send_byte(ext_ts[15:8]); send_byte(ext_ts[7:0]);
    end
    if (ch < TABLE_DEPTH) begin
      l = (f == FMT_FULL || f == FMT_NOSID) ? len : chan_len[ch];
      src = (f != FMT_FULL && f != FMT_NOSID && chan_left[ch] != 0) ? chan_left[ch] : l;
      chan_len[ch] = l;
      chan_left[ch] = src - n;
    end
    for (int k = 0; k < int'(n); k++) send_byte(8'($urandom));
    sent_chunks++;
  endtask

  task random_chunk();
    int          ch, sel;
    logic [1:0]  f;
    logic [23:0] raw_ts, len;
    sel = $urandom_range(0, 9);
    if (sel < 5) ch = $urandom_range(2, 9);
    else if (sel == 5) ch = $urandom_range(2, 63);
    else if (sel == 6) ch = $urandom_range(64, 319);
    else if (sel == 7) ch = $urandom_range(320, TABLE_DEPTH - 1);
    else if (sel == 8) ch = $urandom_range(TABLE_DEPTH, MAX_CHAN);
    else ch = MAX_CHAN;
    f = 2'($urandom_range(0, 3));
    // keep continuations going where a message is half sent
    if (ch < TABLE_DEPTH && chan_left[ch] != 0 && $urandom_range(0, 2) != 0)
      f = $urandom_range(0, 1) ? FMT_NONE : FMT_TS;
    raw_ts = ($urandom_range(0, 9) == 0) ? MASK24 : 24'($urandom);
    sel = $urandom_range(0, 19);
    if (sel == 0 && cap_now <= 24'd256) len = MASK24;
    else if (sel < 3) len = 24'd0;
    else len = 24'($urandom_range(1, (cap_now < 16) ? 3 * int'(cap_now) : 60));
    if (payload_bytes(ch, f, len) > 24'd200) begin
      f = FMT_FULL;
      len = 24'($urandom_range(0, 40));
    end
    send_chunk(ch, f, $urandom_range(0, 3) == 0, raw_ts, $urandom, len,
               8'($urandom), $urandom);
  endtask

  task write_max_chunk(input logic [23:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_MAX_CHUNK; pwdata <= {8'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cap_now = (v == 0) ? 24'd1 : v;
    cap_settings++;
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  logic [23:0] cap_plan[6] = '{24'd0, 24'd1, 24'd7, MASK24, 24'd200, MAX_CHUNK_RST};

  initial begin
    int target;
    rst_ni <= 1'b0; psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= '0; pwdata <= '0; in_valid_i <= 1'b0; in_byte_i <= '0;
    quiet = 1'b0; hold_req = 1'b0;
    sent_bytes = 0; sent_chunks = 0; cap_settings = 0;
    for (int k = 0; k <= MAX_CHAN; k++) begin
      chan_len[k] = '0; chan_left[k] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_max_chunk(MAX_CHUNK_RST);

    // directed: header forms, extremes, extended and wrapping timestamps
    send_chunk(2, FMT_FULL, 0, 24'h000000, 0, 24'd2, 8'h00, 32'h0000_0000);
    send_chunk(63, FMT_FULL, 0, MASK24, 32'hFFFF_FFFF, 24'd0, 8'hFF, 32'hFFFF_FFFF);
    send_chunk(63, FMT_NOSID, 0, MASK24, 32'h0000_0002, 24'd1, 8'h5A, 0);
    send_chunk(319, FMT_FULL, 0, 24'hFFFFFE, 0, 24'd300, 8'h14, 32'h0102_0304);
    send_chunk(319, FMT_NONE, 0, 0, 0, 0, 0, 0);
    send_chunk(319, FMT_TS, 0, 24'd10, 0, 0, 0, 0);
    send_chunk(64, FMT_TS, 1, 24'h00_0001, 0, 0, 0, 0);
    send_chunk(MAX_CHAN, FMT_FULL, 0, 24'h123456, 0, 24'd1, 8'h09, 32'h8000_0001);
    send_chunk(600, FMT_NONE, 0, 0, 0, 0, 0, 0);
    send_chunk(5, FMT_NONE, 0, 0, 0, 0, 0, 0);

    for (int p = 0; p <= 6; p++) begin
      if (p > 0) begin
        drain();
        write_max_chunk(cap_plan[p - 1]);
      end
      if (p == 6) quiet = 1'b1;
      if (p == 1) hold_req = 1'b1;
      target = sent_bytes + PHASE_BYTES;
      while (sent_bytes < target) begin
        random_chunk();
      end
    end
    drain();

    $display("stream of %0d bytes in %0d chunks, %0d chunk size settings, checked",
             sent_bytes, sent_chunks, cap_settings);
    if (fail_count == 0) begin
      $display("[rtmp_chunk_stream_parser] OK");
    end else begin
      $display("[rtmp_chunk_stream_parser] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rcsp_pkg.sv
sv/rcsp_ram.sv
sv/rcsp_hist.sv
sv/rtmp_chunk_stream_parser.sv
sv/rcsp_checker.sv
bench/rtmp_chunk_checker.sv
bench/rtmp_chunk_stream_parser_tb.sv
